/* hdl/potential_field_steering_macros.svh */
// ----------------------------------------------------------------------------
// Potential field steering assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POTENTIAL_FIELD_STEERING_MACROS_SVH
`define POTENTIAL_FIELD_STEERING_MACROS_SVH
`ifndef SYNTHESIS
`define PFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PFS_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) trig |=> prop) \
    else $error(msg);
`else
`define PFS_ASSERT(label, prop, msg)
`define PFS_ASSERT_NEXT(label, trig, prop, msg)
`endif
`endif

/* hdl/pfs_pkg.sv */
// ----------------------------------------------------------------------------
// Potential field steering package
// Payload types, sequencer states, register indexes and arithmetic helpers.
// ----------------------------------------------------------------------------
package pfs_pkg;

  typedef struct packed {
    logic               func;
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic signed [15:0] pose_yaw;
    logic        [15:0] range_value;
    logic               last_sample;
  } pfs_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] turn_rate;
    logic        [23:0] goal_distance;
    logic               drive_enable;
  } pfs_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DSQ,
    ST_DR,
    ST_NUM,
    ST_DEN,
    ST_BRG,
    ST_ANGLE,
    ST_RUN,
    ST_PX_HI,
    ST_PX_LO,
    ST_PY_HI,
    ST_PY_LO,
    ST_PSUM,
    ST_INDEX,
    ST_SCALE,
    ST_FX_ATT,
    ST_FX_HI,
    ST_FX_LO,
    ST_FY_ATT,
    ST_FY_HI,
    ST_FY_LO,
    ST_DX2,
    ST_DY2,
    ST_SOLVE_GO,
    ST_SOLVE,
    ST_TURN,
    ST_TURN_SAT,
    ST_OUT
  } pfs_state_e;

  typedef enum logic {
    COR_ROTATE,
    COR_VECTOR
  } cor_mode_e;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_GOAL_X     = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GOAL_Y     = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SCAN_START = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SCAN_STEP  = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS     = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ATT_GAIN   = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_REP_GAIN   = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_HEAD_GAIN  = 4'd7;

  localparam int MUL_W    = 33;
  localparam int DIV_QW   = 39;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W = 50;
  localparam int SQRT_W   = 50;
  localparam int ROOT_W   = 25;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 50'sd652032874;
  localparam logic [DIV_QW-1:0] TERM_MAX = '1;
  localparam logic [SQRT_W-1:0] DRIVE_DSQ_MIN = 50'd41943;

  localparam logic signed [63:0] SUM_HI = 64'sd549755813887;
  localparam logic signed [63:0] SUM_LO = -64'sd549755813888;
  localparam logic signed [63:0] S32_HI = 64'sd2147483647;
  localparam logic signed [63:0] S32_LO = -64'sd2147483648;

  function automatic logic [31:0] atan_step(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [39:0] sat_sum(input logic signed [63:0] v);
    logic signed [39:0] r;
    if (v > SUM_HI) begin
      r = SUM_HI[39:0];
    end else if (v < SUM_LO) begin
      r = SUM_LO[39:0];
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_HI) begin
      r = S32_HI[31:0];
    end else if (v < S32_LO) begin
      r = S32_LO[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/pfs_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33x33 multiply with registered product.
// ----------------------------------------------------------------------------
module pfs_mul import pfs_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [MUL_W-1:0]   a_i,
  input  logic signed [MUL_W-1:0]   b_i,
  output logic signed [2*MUL_W-1:0] p_o
);

  logic signed [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

/* hdl/pfs_div.sv */
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle; flags quotients that do not fit DIV_QW bits.
// ----------------------------------------------------------------------------
module pfs_div import pfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [63:0]       num_i,
  input  logic [63:0]       den_i,
  output logic              busy_o,
  output logic [DIV_QW-1:0] quo_o,
  output logic              ovf_o
);

  logic              busy_q;
  logic [5:0]        cnt_q;
  logic [63:0]       rem_q;
  logic [63:0]       den_q;
  logic [DIV_QW-1:0] num_q;
  logic [DIV_QW-1:0] quo_q;
  logic              ovf_q;
  logic [64:0]       trial;
  logic [64:0]       diff;
  logic              fits;
  logic [63:0]       rem_init;

  assign rem_init = {{DIV_QW{1'b0}}, num_i[63:DIV_QW]};
  assign trial    = {rem_q, num_q[DIV_QW-1]};
  assign diff     = trial - {1'b0, den_q};
  assign fits     = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'(DIV_QW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init;
      num_q <= num_i[DIV_QW-1:0];
      den_q <= den_i;
      ovf_q <= rem_init >= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[63:0] : trial[63:0];
      quo_q <= {quo_q[DIV_QW-2:0], fits};
      num_q <= {num_q[DIV_QW-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

/* hdl/pfs_sqrt.sv */
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pfs_sqrt import pfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQRT_W-1:0] val_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  logic              busy_q;
  logic [SQRT_W-1:0] v_q;
  logic [SQRT_W-1:0] r_q;
  logic [SQRT_W-1:0] bit_q;
  logic [SQRT_W-1:0] trial;
  logic              take;

  assign trial = r_q + bit_q;
  assign take  = v_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      r_q   <= '0;
      bit_q <= SQRT_W'(1) << (SQRT_W - 2);
    end else if (busy_q) begin
      if (take) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule

/* hdl/pfs_cordic.sv */
// ----------------------------------------------------------------------------
// CORDIC engine
// Rotation mode gives cosine and sine of a bearing; vectoring gives atan2.
// ----------------------------------------------------------------------------
module pfs_cordic import pfs_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  cor_mode_e                  mode_i,
  input  logic [15:0]                angle_i,
  input  logic signed [31:0]         vec_x_i,
  input  logic signed [31:0]         vec_y_i,
  output logic                       busy_o,
  output logic signed [CORDIC_W-1:0] cos_o,
  output logic signed [CORDIC_W-1:0] sin_o,
  output logic [15:0]                angle_o
);

  logic                       busy_q;
  logic [4:0]                 cnt_q;
  cor_mode_e                  mode_q;
  logic                       neg_q;
  logic signed [CORDIC_W-1:0] x_q;
  logic signed [CORDIC_W-1:0] y_q;
  logic signed [32:0]         z_q;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [CORDIC_W-1:0] vx;
  logic signed [CORDIC_W-1:0] vy;
  logic signed [32:0]         step;
  logic                       dir_pos;
  logic [31:0]                z_round;

  assign xs   = x_q >>> cnt_q;
  assign ys   = y_q >>> cnt_q;
  assign step = {1'b0, atan_step(cnt_q)};
  assign vx   = {{2{vec_x_i[31]}}, vec_x_i, 16'b0};
  assign vy   = {{2{vec_y_i[31]}}, vec_y_i, 16'b0};

  always_comb begin
    if (mode_q == COR_ROTATE) begin
      dir_pos = !z_q[32];
    end else begin
      dir_pos = y_q[CORDIC_W-1] || (y_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= mode_i;
      if (mode_i == COR_ROTATE) begin
        // fold the left half-plane onto the right one and negate at the end
        neg_q <= angle_i[15] ^ angle_i[14];
        x_q   <= CORDIC_GAIN;
        y_q   <= '0;
        z_q   <= {angle_i[14], angle_i[14], angle_i[14:0], 16'b0};
      end else begin
        neg_q <= 1'b0;
        if (vec_x_i[31]) begin
          x_q <= -vx;
          y_q <= -vy;
          z_q <= 33'h0_8000_0000;
        end else begin
          x_q <= vx;
          y_q <= vy;
          z_q <= '0;
        end
      end
    end else if (busy_q) begin
      if (dir_pos) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - step;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + step;
      end
    end
  end

  assign z_round = z_q[31:0] + 32'h0000_8000;
  assign busy_o  = busy_q;
  assign cos_o   = neg_q ? -x_q : x_q;
  assign sin_o   = neg_q ? -y_q : y_q;
  assign angle_o = z_round[31:16];

endmodule

/* hdl/potential_field_steering.sv */
// ----------------------------------------------------------------------------
// Potential field steering
// Accumulates obstacle repulsion over a laser scan and, at the last sample,
// emits the total force, heading command, goal distance and drive enable.
// ----------------------------------------------------------------------------
//  channel  signals                          direction
//  in       in_valid_i in_ready_o in_data_i  sink, pose update or range sample
//  out      out_valid_o out_ready_i out_data_o  source, one per finished scan
//  cfg      cfg_we_i cfg_addr_i cfg_wdata_i  write only, no wait
//
// A pose update is taken in the idle state; a sample at or beyond the influence
// radius passes through the index step only. A repelling sample runs the
// 39-step divider for the repulsion magnitude. A last sample adds the scan
// scale divider, then CORDIC vectoring alongside the square root.
// in_ready_o is high only while the sequencer idles; a finished result waits
// in the output register and stalls the sequencer once the next result is ready.
// ----------------------------------------------------------------------------
`include "potential_field_steering_macros.svh"

module potential_field_steering import pfs_pkg::*; #(
  parameter int NOMINAL_POINTS = 640,
  parameter int MAX_SAMPLES    = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pfs_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pfs_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int IDX_W   = $clog2(MAX_SAMPLES);
  localparam int SCALE_W = $clog2(NOMINAL_POINTS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

  pfs_state_e state_q, state_d;

  logic signed [23:0] goal_x_q, goal_y_q;
  logic [15:0]        start_q, step_q, radius_q, rep_gain_q, head_gain_q;
  logic signed [15:0] att_gain_q;

  logic signed [23:0] robot_x_q, robot_y_q;
  logic signed [15:0] heading_q;
  logic [IDX_W-1:0]   idx_q;
  logic signed [39:0] sum_x_q, sum_y_q;

  logic [15:0]         d_q;
  logic                last_q;
  logic [31:0]         dd_q, dr_q;
  logic [63:0]         num_q;
  logic [DIV_QW-1:0]   t_q;
  logic signed [17:0]  cs_q, sn_q;
  logic signed [63:0]  acc_q;
  logic [SCALE_W-1:0]  scale_q;
  logic signed [31:0]  fx_q, fy_q, turn_q;
  logic [SQRT_W-1:0]   dsq_q;

  logic     out_valid_q;
  pfs_out_t out_q;

  logic                       in_fire, out_free;
  logic [15:0]                rng_d;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [2*MUL_W-1:0]  mul_p;
  logic signed [63:0]         p64, prod_w;
  logic signed [63:0]         sum_x_w, sum_y_w;
  logic signed [24:0]         dx_w, dy_w;
  logic [15:0]                brg_w;
  logic signed [16:0]         err_w;
  logic [15:0]                atan_w;
  logic [SQRT_W-1:0]          dsq_w;

  logic               div_start, div_busy, div_ovf;
  logic [63:0]        div_num, div_den;
  logic [DIV_QW-1:0]  div_quo;
  logic               cor_start, cor_busy;
  cor_mode_e          cor_mode;
  logic signed [CORDIC_W-1:0] cor_cos, cor_sin;
  logic [15:0]        cor_angle;
  logic               sqrt_start, sqrt_busy;
  logic [ROOT_W-1:0]  sqrt_root;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign rng_d      = (in_data_i.range_value == '0) ? 16'd1 : in_data_i.range_value;

  assign p64     = mul_p[63:0];
  assign prod_w  = acc_q + p64;
  assign sum_x_w = 64'(sum_x_q) - (prod_w >>> 15);
  assign sum_y_w = 64'(sum_y_q) - (prod_w >>> 15);
  assign dx_w    = 25'(robot_x_q) - 25'(goal_x_q);
  assign dy_w    = 25'(robot_y_q) - 25'(goal_y_q);
  assign brg_w   = start_q + p64[15:0] + heading_q;
  assign atan_w  = ((fx_q == '0) && (fy_q == '0)) ? 16'd0 : cor_angle;
  assign err_w   = 17'($signed(atan_w)) - 17'(heading_q);
  assign dsq_w   = dsq_q + p64[SQRT_W-1:0];

  pfs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pfs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf)
  );

  pfs_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .mode_i  (cor_mode),
    .angle_i (brg_w),
    .vec_x_i (fx_q),
    .vec_y_i (fy_q),
    .busy_o  (cor_busy),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin),
    .angle_o (cor_angle)
  );

  pfs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (dsq_w),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_data_i.func) begin
          state_d = (rng_d < radius_q) ? ST_DSQ : ST_INDEX;
        end
      end
      ST_DSQ:    state_d = ST_DR;
      ST_DR:     state_d = ST_NUM;
      ST_NUM:    state_d = ST_DEN;
      ST_DEN:    state_d = ST_BRG;
      ST_BRG:    state_d = ST_ANGLE;
      ST_ANGLE:  state_d = ST_RUN;
      ST_RUN: begin
        if (!div_busy && !cor_busy) begin
          state_d = ST_PX_HI;
        end
      end
      ST_PX_HI:  state_d = ST_PX_LO;
      ST_PX_LO:  state_d = ST_PY_HI;
      ST_PY_HI:  state_d = ST_PY_LO;
      ST_PY_LO:  state_d = ST_PSUM;
      ST_PSUM:   state_d = ST_INDEX;
      ST_INDEX:  state_d = last_q ? ST_SCALE : ST_IDLE;
      ST_SCALE: begin
        if (!div_busy) begin
          state_d = ST_FX_ATT;
        end
      end
      ST_FX_ATT:   state_d = ST_FX_HI;
      ST_FX_HI:    state_d = ST_FX_LO;
      ST_FX_LO:    state_d = ST_FY_ATT;
      ST_FY_ATT:   state_d = ST_FY_HI;
      ST_FY_HI:    state_d = ST_FY_LO;
      ST_FY_LO:    state_d = ST_DX2;
      ST_DX2:      state_d = ST_DY2;
      ST_DY2:      state_d = ST_SOLVE_GO;
      ST_SOLVE_GO: state_d = ST_SOLVE;
      ST_SOLVE: begin
        if (!cor_busy && !sqrt_busy) begin
          state_d = ST_TURN;
        end
      end
      ST_TURN:     state_d = ST_TURN_SAT;
      ST_TURN_SAT: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // unit operands and start strobes
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = num_q;
    div_den    = p64;
    cor_start  = 1'b0;
    cor_mode   = COR_ROTATE;
    sqrt_start = 1'b0;
    case (state_q)
      ST_DSQ: begin
        mul_a = 33'(d_q);
        mul_b = 33'(d_q);
      end
      ST_DR: begin
        mul_a = 33'(d_q);
        mul_b = 33'(radius_q);
      end
      ST_NUM: begin
        mul_a = 33'(rep_gain_q);
        mul_b = 33'(radius_q - d_q);
      end
      ST_DEN: begin
        mul_a = 33'(dd_q);
        mul_b = 33'(dr_q);
      end
      ST_BRG: begin
        mul_a     = 33'(idx_q);
        mul_b     = 33'($signed(step_q));
        div_start = 1'b1;
      end
      ST_ANGLE: begin
        cor_start = 1'b1;
      end
      ST_PX_HI: begin
        mul_a = 33'(t_q[DIV_QW-1:20]);
        mul_b = 33'(cs_q);
      end
      ST_PX_LO: begin
        mul_a = 33'(t_q[19:0]);
        mul_b = 33'(cs_q);
      end
      ST_PY_HI: begin
        mul_a = 33'(t_q[DIV_QW-1:20]);
        mul_b = 33'(sn_q);
      end
      ST_PY_LO: begin
        mul_a = 33'(t_q[19:0]);
        mul_b = 33'(sn_q);
      end
      ST_INDEX: begin
        div_start = last_q;
        div_num   = 64'(NOMINAL_POINTS);
        div_den   = 64'(idx_q) + 64'd1;
      end
      ST_FX_ATT: begin
        mul_a = 33'(att_gain_q);
        mul_b = 33'(dx_w);
      end
      ST_FX_HI: begin
        mul_a = 33'(scale_q);
        mul_b = 33'($signed(sum_x_q[39:20]));
      end
      ST_FX_LO: begin
        mul_a = 33'(scale_q);
        mul_b = 33'(sum_x_q[19:0]);
      end
      ST_FY_ATT: begin
        mul_a = 33'(att_gain_q);
        mul_b = 33'(dy_w);
      end
      ST_FY_HI: begin
        mul_a = 33'(scale_q);
        mul_b = 33'($signed(sum_y_q[39:20]));
      end
      ST_FY_LO: begin
        mul_a = 33'(scale_q);
        mul_b = 33'(sum_y_q[19:0]);
      end
      ST_DX2: begin
        mul_a = 33'(dx_w);
        mul_b = 33'(dx_w);
      end
      ST_DY2: begin
        mul_a = 33'(dy_w);
        mul_b = 33'(dy_w);
      end
      ST_SOLVE_GO: begin
        cor_start  = 1'b1;
        cor_mode   = COR_VECTOR;
        sqrt_start = 1'b1;
      end
      ST_TURN: begin
        mul_a = 33'(head_gain_q);
        mul_b = 33'(err_w);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q    <= 24'sd10240;
      goal_y_q    <= '0;
      start_q     <= '0;
      step_q      <= '0;
      radius_q    <= 16'd1536;
      att_gain_q  <= -16'sd1280;
      rep_gain_q  <= 16'd4915;
      head_gain_q <= 16'd90;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_GOAL_X:     goal_x_q    <= cfg_wdata_i;
        REG_GOAL_Y:     goal_y_q    <= cfg_wdata_i;
        REG_SCAN_START: start_q     <= cfg_wdata_i[15:0];
        REG_SCAN_STEP:  step_q      <= cfg_wdata_i[15:0];
        REG_RADIUS:     radius_q    <= cfg_wdata_i[15:0];
        REG_ATT_GAIN:   att_gain_q  <= cfg_wdata_i[15:0];
        REG_REP_GAIN:   rep_gain_q  <= cfg_wdata_i[15:0];
        REG_HEAD_GAIN:  head_gain_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // robot pose, scan position and repulsion sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robot_x_q <= '0;
      robot_y_q <= '0;
      heading_q <= '0;
      idx_q     <= '0;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
    end else begin
      if (in_fire && !in_data_i.func) begin
        robot_x_q <= in_data_i.pose_x;
        robot_y_q <= in_data_i.pose_y;
        heading_q <= in_data_i.pose_yaw;
      end
      case (state_q)
        ST_PY_HI: sum_x_q <= sat_sum(sum_x_w);
        ST_PSUM:  sum_y_q <= sat_sum(sum_y_w);
        ST_INDEX: begin
          // hold the last bearing index on an overlong scan
          if (!last_q && (idx_q != IDX_LAST)) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            idx_q   <= '0;
            sum_x_q <= '0;
            sum_y_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      d_q    <= rng_d;
      last_q <= in_data_i.last_sample;
    end
    case (state_q)
      ST_DR:    dd_q  <= p64[31:0];
      ST_NUM:   dr_q  <= p64[31:0];
      ST_DEN:   num_q <= {p64[33:0], 30'b0};
      ST_RUN: begin
        t_q  <= div_ovf ? TERM_MAX : div_quo;
        cs_q <= cor_cos[32:15];
        sn_q <= cor_sin[32:15];
      end
      ST_PX_LO:  acc_q <= p64 <<< 20;
      ST_PY_LO:  acc_q <= p64 <<< 20;
      ST_SCALE:  scale_q <= div_quo[SCALE_W-1:0];
      ST_FX_HI:  acc_q <= p64 >>> 2;
      ST_FX_LO:  acc_q <= acc_q + (p64 <<< 20);
      ST_FY_ATT: fx_q  <= sat32(prod_w);
      ST_FY_HI:  acc_q <= p64 >>> 2;
      ST_FY_LO:  acc_q <= acc_q + (p64 <<< 20);
      ST_DX2:    fy_q  <= sat32(prod_w);
      ST_DY2:    dsq_q <= p64[SQRT_W-1:0];
      ST_SOLVE_GO: dsq_q <= dsq_w;
      ST_TURN_SAT: turn_q <= sat32(p64);
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      out_q.force_x       <= fx_q;
      out_q.force_y       <= fy_q;
      out_q.turn_rate     <= turn_q;
      out_q.goal_distance <= sqrt_root[ROOT_W-1] ? 24'hFF_FFFF : sqrt_root[23:0];
      out_q.drive_enable  <= dsq_q > DRIVE_DSQ_MIN;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PFS_ASSERT(a_idle_units, in_ready_o |-> !(div_busy || cor_busy || sqrt_busy), "unit busy while idle")
  `PFS_ASSERT(a_div_free, div_start |-> !div_busy, "divider restarted while busy")
  `PFS_ASSERT_NEXT(a_scan_clear, (state_q == ST_OUT) && out_free, (idx_q == '0) && (sum_x_q == '0) && (sum_y_q == '0), "scan state not cleared")

endmodule
